// File: design/bspline_de_boor_eval_assert.svh
// Assertion macros for the B-spline evaluator.
// Used by the top level only; no other dependencies.
`ifndef BSPLINE_DE_BOOR_EVAL_ASSERT_SVH
`define BSPLINE_DE_BOOR_EVAL_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BSP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bspline check failed");
// Next-cycle implication checked outside reset.
`define BSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bspline check failed");
`endif

// File: design/bsp_pkg.sv
// Package for the B-spline evaluator: sizes, request, status and register codes, divider request.
// No dependencies.
`default_nettype none
package bsp_pkg;
  localparam int MaxKnots  = 64;
  localparam int MaxCtrl   = 64;
  localparam int MaxDegree = 7;

  localparam logic [1:0] REQ_WR_KNOT = 2'd0;
  localparam logic [1:0] REQ_WR_CTRL = 2'd1;
  localparam logic [1:0] REQ_EV_SRCH = 2'd2;
  localparam logic [1:0] REQ_EV_SPAN = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_KNOTS  = 1'b1;

  typedef struct packed {
    logic start;
    logic signed [48:0] dividend;
    logic signed [32:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

// File: design/bspline_de_boor_eval.sv
// B-spline evaluator top level: stores, span search and de Boor sequencer.
// Depends on bsp_pkg, bsp_div and bspline_de_boor_eval_assert.svh.
//
//  channel | ports                                     | handshake
//  input   | in_req_type in_slot in_data_value in_span_in | start & !busy
//  result  | out_spline_value out_span_used out_status | out_valid, one cycle
//  config  | cfg_we cfg_index cfg_wdata                | cfg_we
//
// A write stores its word at acceptance, then passes through S_WR, which reports ST_WRITE.
// An evaluation runs the span search (REQ_EV_SRCH only; states S_SR_A, S_SR_B and
// S_SR_C per interval tested), a range check in S_CHK, a load of each point
// through S_LD and S_LDW, then degree*(degree+1)/2 interpolations, each through
// S_KA, S_KB, S_KC, the bit-serial divider in S_DIV (a zero spacing skips it),
// S_MUL and S_UPD. Reset clears only the control state; stores are undefined
// until written. Results cannot be stalled.
`default_nettype none
module bspline_de_boor_eval (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [5:0]         in_slot,
  input  wire logic signed [31:0] in_data_value,
  input  wire logic [5:0]         in_span_in,
  output logic                    out_valid,
  output logic signed [31:0]      out_spline_value,
  output logic [5:0]              out_span_used,
  output logic [1:0]              out_status,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [6:0]         cfg_wdata
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SR_A = 4'd1, S_SR_B = 4'd2, S_SR_C = 4'd3,
    S_CHK = 4'd4, S_LD = 4'd5, S_LDW = 4'd6, S_KA = 4'd7, S_KB = 4'd8, S_KC = 4'd9,
    S_DIV = 4'd10, S_MUL = 4'd11, S_UPD = 4'd12, S_DONE = 4'd13, S_WR = 4'd14;

  logic [3:0]  st_r;
  logic [2:0]  deg_r;
  logic [6:0]  kc_r;
  logic signed [31:0] x_r;
  logic [5:0]  span_r;
  logic [1:0]  stat_r;
  // knot and control memories, one registered read port each
  logic signed [31:0] knot_mem [bsp_pkg::MaxKnots];
  logic signed [31:0] ctrl_mem [bsp_pkg::MaxCtrl];
  logic [5:0]  kaddr;
  logic signed [31:0] kq_r, cq_r, ta_r;
  logic [6:0]  i_r;
  logic [5:0]  last_r;
  logic        found_r;
  logic signed [31:0] wp_r [bsp_pkg::MaxDegree + 1];
  logic [2:0]  j_r, r_r, ld_r;
  logic signed [32:0] num_r, den_r;
  logic signed [32:0] den_now;
  logic signed [31:0] alpha_r;
  logic signed [64:0] prod_r;
  bsp_pkg::div_req_t dreq;
  logic        ddone;
  logic signed [49:0] dq;
  logic [6:0]  kc_use;
  logic [7:0]  hi_idx;
  logic [6:0]  base;
  logic signed [32:0] diff;
  logic signed [64:0] stp;
  logic signed [47:0] sum;

  assign kc_use = (kc_r > 7'(bsp_pkg::MaxKnots)) ? 7'(bsp_pkg::MaxKnots) : kc_r;
  assign base = 7'(span_r) - 7'(deg_r);
  assign diff = 33'(wp_r[j_r]) - 33'(wp_r[j_r - 3'd1]);
  // knot spacing from t[i] (held) and t[i+1+p-r] (just read)
  assign den_now = 33'(kq_r) - 33'(ta_r);

  bsp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  always_comb begin
    dreq.start = (st_r == S_KC) && (den_now != '0);
    dreq.dividend = {num_r, 16'd0};
    dreq.divisor = den_now;
    // knot address per state: i, then i+1 (search) or i+1+p-r (interpolation)
    kaddr = i_r[5:0];
    hi_idx = 8'(base) + 8'(j_r) + 8'd1 + 8'(deg_r) - 8'(r_r);
    if (st_r == S_SR_B) kaddr = 6'(i_r + 7'd1);
    if (st_r == S_KA) kaddr = 6'(base + 7'(j_r));
    if (st_r == S_KB) kaddr = hi_idx[5:0];
    stp = prod_r / 65'sd65536;
    sum = 48'(wp_r[j_r - 3'd1]) + 48'(stp);
  end

  always_ff @(posedge clk) begin
    kq_r <= knot_mem[kaddr];
    cq_r <= ctrl_mem[6'(base + 7'(ld_r))];
    if (start && !busy && in_req_type == bsp_pkg::REQ_WR_KNOT)
      knot_mem[in_slot] <= in_data_value;
    if (start && !busy && in_req_type == bsp_pkg::REQ_WR_CTRL)
      ctrl_mem[in_slot] <= in_data_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; deg_r <= 3'd3; kc_r <= 7'd8; out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == bsp_pkg::CFG_DEGREE) deg_r <= cfg_wdata[2:0];
        else kc_r <= cfg_wdata;
      end
      unique case (st_r)
        S_IDLE: if (start) begin
          x_r <= in_data_value;
          span_r <= in_span_in; stat_r <= bsp_pkg::ST_OK;
          i_r <= '0; last_r <= '0; found_r <= 1'b0;
          if (in_req_type == bsp_pkg::REQ_WR_KNOT || in_req_type == bsp_pkg::REQ_WR_CTRL)
            st_r <= S_WR;
          else if (in_req_type == bsp_pkg::REQ_EV_SRCH) st_r <= S_SR_A;
          else st_r <= S_CHK;
        end
        S_WR: begin
          out_spline_value <= '0; out_span_used <= '0;
          out_status <= bsp_pkg::ST_WRITE; out_valid <= 1'b1; st_r <= S_IDLE;
        end
        // linear span search: fetch t[i], then t[i+1]
        S_SR_A: if (i_r + 7'd1 >= kc_use || found_r) begin
          span_r <= found_r ? span_r : last_r; st_r <= S_CHK;
        end else st_r <= S_SR_B;
        S_SR_B: begin ta_r <= kq_r; st_r <= S_SR_C; end
        S_SR_C: begin
          if (ta_r < kq_r) begin
            last_r <= i_r[5:0];
            if (ta_r <= x_r && x_r < kq_r) begin
              found_r <= 1'b1; span_r <= i_r[5:0];
            end
          end
          i_r <= i_r + 7'd1; st_r <= S_SR_A;
        end
        S_CHK: begin
          if (span_r < 6'(deg_r) || 8'(span_r) + 8'(deg_r) + 8'd1 > 8'(kc_use)) begin
            out_spline_value <= '0; out_span_used <= span_r;
            out_status <= bsp_pkg::ST_RANGE; out_valid <= 1'b1; st_r <= S_IDLE;
          end else begin
            ld_r <= '0; st_r <= S_LD;
          end
        end
        // load control points base..span into the work registers
        S_LD: st_r <= S_LDW;
        S_LDW: begin
          wp_r[ld_r] <= cq_r;
          if (ld_r == deg_r) begin
            r_r <= 3'd1; j_r <= deg_r;
            st_r <= (deg_r == 3'd0) ? S_DONE : S_KA;
          end else begin
            ld_r <= ld_r + 3'd1; st_r <= S_LD;
          end
        end
        S_KA: st_r <= S_KB;
        S_KB: begin ta_r <= kq_r; num_r <= 33'(x_r) - 33'(kq_r); st_r <= S_KC; end
        S_KC: begin
          den_r <= den_now;
          st_r <= S_DIV;
        end
        S_DIV: if (den_r == '0) begin
          alpha_r <= '0; stat_r <= bsp_pkg::ST_ZERO; st_r <= S_MUL;
        end else if (ddone) begin
          if (dq > 50'sd1073741823) alpha_r <= 32'sd1073741823;
          else if (dq < -50'sd1073741824) alpha_r <= -32'sd1073741824;
          else alpha_r <= 32'(dq);
          st_r <= S_MUL;
        end
        S_MUL: begin prod_r <= 65'(alpha_r) * 65'(diff); st_r <= S_UPD; end
        S_UPD: begin
          if (sum > 48'sd2147483647) wp_r[j_r] <= 32'sh7fffffff;
          else if (sum < -48'sd2147483648) wp_r[j_r] <= 32'sh80000000;
          else wp_r[j_r] <= 32'(sum);
          if (j_r == r_r) begin
            if (r_r == deg_r) st_r <= S_DONE;
            else begin r_r <= r_r + 3'd1; j_r <= deg_r; st_r <= S_KA; end
          end else begin
            j_r <= j_r - 3'd1; st_r <= S_KA;
          end
        end
        S_DONE: begin
          out_spline_value <= wp_r[deg_r]; out_span_used <= span_r;
          out_status <= stat_r; out_valid <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE);

`include "bspline_de_boor_eval_assert.svh"
  `BSP_ASSERT_NEXT(a_take, start && !busy, busy)
  `BSP_ASSERT_IMPL(a_wr_status, out_valid && out_status == bsp_pkg::ST_WRITE, out_span_used == 6'd0)
  `BSP_ASSERT_IMPL(a_div_busy, st_r == S_DIV, busy)
endmodule
`default_nettype wire

// File: design/bsp_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// Depends on bsp_pkg.
`default_nettype none
module bsp_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bsp_pkg::div_req_t req,
  output logic                   done,
  output logic signed [49:0]     quot
);
  logic [48:0] rem_r, rem_nxt;
  logic [48:0] q_r, q_nxt;
  logic [32:0] dv_r, dv_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [49:0] trial;
  logic [48:0] ua;
  logic [32:0] ub;

  always_comb begin
    ua = req.dividend[48] ? 49'(-req.dividend) : 49'(req.dividend);
    ub = req.divisor[32] ? 33'(-req.divisor) : 33'(req.divisor);
    rem_nxt = rem_r; q_nxt = q_r; dv_nxt = dv_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; run_nxt = run_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[48]} - {17'd0, dv_r};
    if (req.start) begin
      rem_nxt = '0; q_nxt = ua; dv_nxt = ub;
      neg_nxt = req.dividend[48] ^ req.divisor[32];
      cnt_nxt = 6'd48; run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[49]) begin
        rem_nxt = trial[48:0]; q_nxt = {q_r[47:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[47:0], q_r[48]}; q_nxt = {q_r[47:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        run_nxt = 1'b0; done_nxt = 1'b1;
      end
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; q_r <= q_nxt; dv_r <= dv_nxt; neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r <= 1'b0; done_r <= 1'b0;
    end else begin
      run_r <= run_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
endmodule
`default_nettype wire
